// ===== design/fsd_pkg.sv =====
// Shared types and defaults for the searchable FIFO.
package fsd_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int ITEM_BITS_DEF = 32;
  localparam int CMD_W         = 3;
  localparam int VAL_W         = 32;
  localparam int COUNT_W       = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH     = 3'd0,
    CMD_POP      = 3'd1,
    CMD_REMOVE   = 3'd2,
    CMD_CONTAINS = 3'd3,
    CMD_PEEK     = 3'd4,
    CMD_PURGE    = 3'd5
  } cmd_t;

  // Per-cell control: load the broadcast value, or take the right neighbor's value.
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

// ===== design/fifo_with_search_and_delete.sv =====
// Top level of the FIFO with search and delete: control, counter and the row of cells.
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+-------------------------------------------
//  in_     | input     | in_valid / in_stall  | in_cmd[2:0], in_item_value[31:0]
//  out_    | output    | out_valid / out_stall| out_ok, out_data_out[31:0], out_count_after[4:0]
//
// Timing: push, pop, peek, purge and unused codes finish in the accept cycle; the result
//   register shows them on the next cycle. Remove and contains scan the cells from the
//   front, one cell per cycle, with a scan pointer over the row of cells.
// Reset: synchronous, active low; clears the count, the controller and the result valid.
//   Cell contents are not cleared; only entries below the count are ever read.
// Stalls: a new transaction is taken only in idle, while the result register is empty or being drained.
module fifo_with_search_and_delete
  import fsd_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int ITEM_BITS = ITEM_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CMD_W-1:0]   in_cmd,
  input  logic [VAL_W-1:0]   in_item_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_ok,
  output logic [VAL_W-1:0]   out_data_out,
  output logic [COUNT_W-1:0] out_count_after
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  // Controller state
  state_t               state_r,  state_nxt;
  logic [CNT_W-1:0]     cnt_r,    cnt_nxt;
  logic [IDX_W-1:0]     pos_r,    pos_nxt;
  cmd_t                 cmd_r,    cmd_nxt;
  logic [ITEM_BITS-1:0] val_r,    val_nxt;

  // Result register
  logic                 out_valid_r;
  logic                 out_ok_r;
  logic [VAL_W-1:0]     out_data_r;
  logic [COUNT_W-1:0]   out_count_r;

  // Transaction handshake
  logic in_take;
  assign in_stall = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign in_take  = in_valid && !in_stall;

  // Incoming value cut or widened to the stored width
  logic [ITEM_BITS+VAL_W-1:0] in_ext;
  logic [ITEM_BITS-1:0]       in_val;
  assign in_ext = {{ITEM_BITS{1'b0}}, in_item_value};
  assign in_val = in_ext[ITEM_BITS-1:0];

  // Row of cells
  logic [ITEM_BITS-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]     hit_vec;
  cell_ctrl_t           cell_ctrl [DEPTH];

  logic                 load_en;
  logic                 shift_en;
  logic [IDX_W-1:0]     shift_from;
  logic [ITEM_BITS-1:0] wr_val;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ITEM_BITS-1:0] nbr;
    if (i < DEPTH - 1) begin : g_mid
      assign nbr = cell_data[i+1];
    end else begin : g_last
      assign nbr = cell_data[i];
    end

    // Push writes the first free cell; a delete pulls every cell at or after the gap.
    assign cell_ctrl[i].load  = load_en && (cnt_r == CNT_W'(i));
    assign cell_ctrl[i].shift = shift_en && (IDX_W'(i) >= shift_from);

    fsd_cell #(
      .ITEM_BITS (ITEM_BITS)
    ) u_cell (
      .clk     (clk),
      .ctrl    (cell_ctrl[i]),
      .wr_val  (wr_val),
      .nbr_val (nbr),
      .key     (val_r),
      .data    (cell_data[i]),
      .hit     (hit_vec[i])
    );
  end

  // Result build
  logic                 res_go;
  logic                 res_ok;
  logic [ITEM_BITS-1:0] res_data;
  logic                 scan_hit;
  logic                 scan_last;

  assign scan_hit  = hit_vec[pos_r];
  assign scan_last = (CNT_W'(pos_r) + CNT_W'(1)) == cnt_r;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    pos_nxt    = pos_r;
    cmd_nxt    = cmd_r;
    val_nxt    = val_r;
    res_go     = 1'b0;
    res_ok     = 1'b0;
    res_data   = '0;
    load_en    = 1'b0;
    shift_en   = 1'b0;
    shift_from = '0;
    wr_val     = in_val;

    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          cmd_nxt = cmd_t'(in_cmd);
          val_nxt = in_val;
          case (cmd_t'(in_cmd))
            CMD_PUSH: begin
              res_go = 1'b1;
              if (cnt_r < CNT_W'(DEPTH)) begin
                load_en = 1'b1;
                cnt_nxt = cnt_r + CNT_W'(1);
                res_ok  = 1'b1;
              end
            end
            CMD_POP: begin
              res_go = 1'b1;
              if (cnt_r != '0) begin
                res_data = cell_data[0];
                shift_en = 1'b1;
                cnt_nxt  = cnt_r - CNT_W'(1);
                res_ok   = 1'b1;
              end
            end
            CMD_REMOVE, CMD_CONTAINS: begin
              // Empty queue: nothing to scan
              if (cnt_r == '0) begin
                res_go = 1'b1;
              end else begin
                state_nxt = ST_SCAN;
                pos_nxt   = '0;
              end
            end
            CMD_PEEK: begin
              res_go = 1'b1;
              if (cnt_r != '0) begin
                res_data = cell_data[0];
                res_ok   = 1'b1;
              end
            end
            CMD_PURGE: begin
              res_go  = 1'b1;
              cnt_nxt = '0;
              res_ok  = 1'b1;
            end
            default: begin
              res_go = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // Oldest match wins: stop at the first hit from the front.
        if (scan_hit) begin
          res_go    = 1'b1;
          res_ok    = 1'b1;
          state_nxt = ST_IDLE;
          if (cmd_r == CMD_REMOVE) begin
            shift_en   = 1'b1;
            shift_from = pos_r;
            cnt_nxt    = cnt_r - CNT_W'(1);
          end
        end else if (scan_last) begin
          res_go    = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          pos_nxt = pos_r + IDX_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result fields sized to the port widths
  logic [ITEM_BITS+VAL_W-1:0] res_data_ext;
  logic [CNT_W+COUNT_W-1:0]   cnt_ext;
  assign res_data_ext = {{VAL_W{1'b0}}, res_data};
  assign cnt_ext      = {{COUNT_W{1'b0}}, cnt_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      pos_r       <= '0;
      cmd_r       <= CMD_PUSH;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pos_r   <= pos_nxt;
      cmd_r   <= cmd_nxt;
      if (res_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    val_r <= val_nxt;
    if (res_go) begin
      out_ok_r    <= res_ok;
      out_data_r  <= res_data_ext[VAL_W-1:0];
      out_count_r <= cnt_ext[COUNT_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_data_out    = out_data_r;
  assign out_count_after = out_count_r;

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (CNT_W'(pos_r) < cnt_r))
    else $error("scan pointer past the last queued entry");

  a_res_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_go |-> !(out_valid_r && out_stall))
    else $error("result written over a stalled result");

  a_scan_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !in_take)
    else $error("transaction taken during a scan");

endmodule

// ===== design/fsd_cell.sv =====
// One storage cell of the queue: holds an entry, shifts toward the front, compares to a key.
module fsd_cell
  import fsd_pkg::*;
#(
  parameter int ITEM_BITS = ITEM_BITS_DEF
) (
  input  logic                 clk,
  input  cell_ctrl_t           ctrl,
  input  logic [ITEM_BITS-1:0] wr_val,
  input  logic [ITEM_BITS-1:0] nbr_val,
  input  logic [ITEM_BITS-1:0] key,
  output logic [ITEM_BITS-1:0] data,
  output logic                 hit
);

  logic [ITEM_BITS-1:0] data_r;
  logic [ITEM_BITS-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.shift) begin
      data_nxt = nbr_val;
    end else if (ctrl.load) begin
      data_nxt = wr_val;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;
  assign hit  = (data_r == key);

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the searchable FIFO: directed corners, then random traffic.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fsd_pkg::*;

  // Command codes the package leaves unnamed; the block must treat them as no-ops.
  localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

  // Remove/contains may walk every cell, so a result can trail its command by a full scan of the row.
  localparam int DRAIN_CYCLES   = 2 * DEPTH_DEF + 4;
  localparam int RANDOM_PER_RUN = 500;
  localparam int MAX_REPORTS    = 10;

  // One result transaction as the block should present it.
  typedef struct packed {
    logic               ok;
    logic [VAL_W-1:0]   data;
    logic [COUNT_W-1:0] count;
  } reply_t;

  logic               clk             = 1'b0;
  logic               rst_n           = 1'b0;
  logic               in_valid        = 1'b0;
  logic               in_stall;
  logic [CMD_W-1:0]   in_cmd          = '0;
  logic [VAL_W-1:0]   in_item_value   = '0;
  logic               out_valid;
  logic               out_stall       = 1'b0;
  logic               out_ok;
  logic [VAL_W-1:0]   out_data_out;
  logic [COUNT_W-1:0] out_count_after;

  // Shadow of the queue contents, front at index 0, and the replies still owed.
  logic [VAL_W-1:0] shadow_queue[$];
  reply_t           expected_replies[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches    = 0;
  int replies_seen  = 0;
  int cmd_tally[8];
  int full_rejects  = 0;   // pushes refused because the queue was full
  int empty_reads   = 0;   // pops or peeks refused because it was empty
  int dup_removes   = 0;   // removes that hit a value queued more than once

  fifo_with_search_and_delete u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_item_value   (in_item_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_ok          (out_ok),
    .out_data_out    (out_data_out),
    .out_count_after (out_count_after)
  );

  // 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Apply one command to the shadow queue and return the reply it should produce.
  function automatic reply_t apply_queue_cmd(logic [CMD_W-1:0] c, logic [VAL_W-1:0] v);
    reply_t r;
    int     hits[$];
    r = '0;
    case (c)
      CMD_PUSH: begin
        if (shadow_queue.size() < DEPTH_DEF) begin
          shadow_queue.push_back(v);
          r.ok = 1'b1;
        end
      end
      CMD_POP: begin
        if (shadow_queue.size() > 0) begin
          r.data = shadow_queue.pop_front();
          r.ok   = 1'b1;
        end
      end
      CMD_REMOVE: begin
        // Oldest match goes; everything behind it moves up one place.
        hits = shadow_queue.find_index(e) with (e == v);
        if (hits.size() > 0) begin
          if (hits.size() > 1) dup_removes++;
          shadow_queue.delete(hits[0]);
          r.ok = 1'b1;
        end
      end
      CMD_CONTAINS: begin
        hits = shadow_queue.find_first_index(e) with (e == v);
        r.ok = (hits.size() > 0);
      end
      CMD_PEEK: begin
        if (shadow_queue.size() > 0) begin
          r.data = shadow_queue[0];
          r.ok   = 1'b1;
        end
      end
      CMD_PURGE: begin
        shadow_queue.delete();
        r.ok = 1'b1;
      end
      default: ;  // spare codes change nothing
    endcase
    r.count = COUNT_W'(shadow_queue.size());
    return r;
  endfunction

  // Present one command, hold it until the block takes it, then log the reply it owes.
  // The payload only changes after acceptance, so a stalled transaction stays put.
  task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [VAL_W-1:0] v);
    reply_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= c;
    in_item_value <= v;
    do @(posedge clk); while (in_stall);
    r = apply_queue_cmd(c, v);
    expected_replies.push_back(r);
    cmd_tally[c]++;
    if (c == CMD_PUSH && !r.ok) full_rejects++;
    if ((c == CMD_POP || c == CMD_PEEK) && !r.ok) empty_reads++;
  endtask

  // Result side: check every accepted transaction against the oldest owed reply,
  // and pick the stall for the next cycle.
  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      replies_seen++;
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("tb: %0t unexpected result ok=%0b data=%h count=%0d",
                   $realtime, out_ok, out_data_out, out_count_after);
      end else begin
        want = expected_replies.pop_front();
        if (out_ok !== want.ok || out_data_out !== want.data ||
            out_count_after !== want.count) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("tb: %0t mismatch exp ok=%0b data=%h count=%0d, got ok=%0b data=%h count=%0d",
                     $realtime, want.ok, want.data, want.count,
                     out_ok, out_data_out, out_count_after);
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Value source for random traffic: often a value that is queued now, so that remove and
  // contains hit often and duplicates pile up; the rest are random words, small values or near-all-ones.
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(4))
      0: return $urandom();
      1: return VAL_W'($urandom_range(5));
      2: return $urandom_range(1) ? '1 : ~(VAL_W'(1) << $urandom_range(VAL_W - 1));
      default: begin
        if (shadow_queue.size() > 0)
          return shadow_queue[$urandom_range(shadow_queue.size() - 1)];
        return $urandom();
      end
    endcase
  endfunction

  // Empty-queue corners: every read-type command and both spare codes must fail cleanly,
  // and purge on empty is included too.
  task automatic test_empty_queue();
    send_cmd(CMD_POP, 32'h0);
    send_cmd(CMD_PEEK, 32'hFFFF_FFFF);
    send_cmd(CMD_REMOVE, 32'h0);
    send_cmd(CMD_CONTAINS, 32'hFFFF_FFFF);
    send_cmd(CMD_SPARE6, 32'hA5A5_A5A5);
    send_cmd(CMD_SPARE7, 32'h5A5A_5A5A);
    send_cmd(CMD_PURGE, 32'h0);
  endtask

  // Fill to capacity with a duplicate at head and tail, then exercise the full,
  // head-removal and tail-removal cases before purging.
  task automatic test_full_and_remove();
    send_cmd(CMD_PUSH, 32'hFFFF_FFFF);
    send_cmd(CMD_PUSH, 32'h0);
    for (int i = 0; i < DEPTH_DEF - 3; i++)
      send_cmd(CMD_PUSH, (i % 2) ? ~(VAL_W'(1) << i) : (VAL_W'(1) << (31 - i)));
    send_cmd(CMD_PUSH, 32'hFFFF_FFFF);
    send_cmd(CMD_PUSH, 32'h1234_5678);        // full: refused
    send_cmd(CMD_CONTAINS, 32'hFFFF_FFFF);
    send_cmd(CMD_REMOVE, 32'hFFFF_FFFF);      // oldest copy is the head
    send_cmd(CMD_REMOVE, 32'hFFFF_FFFF);      // remaining copy is the tail
    send_cmd(CMD_PEEK, 32'h0);
    send_cmd(CMD_POP, 32'h0);
    send_cmd(CMD_PURGE, 32'h0);
  endtask

  // Random traffic. The push bias swings between filling and draining in bursts so
  // the queue spends real time both full and empty.
  task automatic test_random_traffic(input int n_items, input int s_pct, input int r_pct);
    int               push_bias;
    int               roll;
    logic [CMD_W-1:0] c;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    push_bias     = 60;
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0) push_bias = $urandom_range(2) == 0 ? 25 : ($urandom_range(1) ? 55 : 85);
      roll = $urandom_range(99);
      if (roll < 2)
        c = $urandom_range(1) ? CMD_SPARE6 : CMD_SPARE7;
      else if (roll < 4)
        c = CMD_PURGE;
      else if ($urandom_range(99) < push_bias)
        c = CMD_PUSH;
      else begin
        case ($urandom_range(3))
          0:       c = CMD_POP;
          1:       c = CMD_REMOVE;
          2:       c = CMD_CONTAINS;
          default: c = CMD_PEEK;
        endcase
      end
      send_cmd(c, pick_value());
    end
  endtask

  initial begin
    foreach (cmd_tally[k]) cmd_tally[k] = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 14;
    recv_idle_pct = 86;
    test_empty_queue();
    test_full_and_remove();

    // Three idling regimes: slow receiver, slow sender, then back-to-back.
    test_random_traffic(RANDOM_PER_RUN, 14, 86);
    test_random_traffic(RANDOM_PER_RUN, 86, 14);
    test_random_traffic(RANDOM_PER_RUN, 0, 0);

    in_valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d results checked; push %0d pop %0d remove %0d contains %0d peek %0d purge %0d spare %0d",
             replies_seen, cmd_tally[CMD_PUSH], cmd_tally[CMD_POP], cmd_tally[CMD_REMOVE],
             cmd_tally[CMD_CONTAINS], cmd_tally[CMD_PEEK], cmd_tally[CMD_PURGE],
             cmd_tally[CMD_SPARE6] + cmd_tally[CMD_SPARE7]);
    $display("tb: full rejects %0d, empty reads %0d, removes among duplicates %0d, mismatches %0d",
             full_rejects, empty_reads, dup_removes, mismatches);
    if (mismatches == 0 && expected_replies.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest legal run.
  initial begin
    #10ms;
    $display("tb: watchdog expired, %0d replies still owed", expected_replies.size());
    $display("tb: FAIL");
    $finish;
  end

endmodule
